### hw/rtl/assert_macros.svh
// Assertion macros shared by the port pair protocol table RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PPT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("port pair table: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("port pair table: next-cycle check failed");

`endif

### hw/rtl/ppt_pkg.sv
// Package for the port pair protocol table: sizes, codes, shared types and helpers.
// Depends on nothing; used by every module of the block.
package ppt_pkg;

   localparam int TableEntries = 64;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_BAD    = 2'd3;

   localparam logic [2:0] STAT_NEW     = 3'd0;
   localparam logic [2:0] STAT_UPDATED = 3'd1;
   localparam logic [2:0] STAT_REMOVED = 3'd2;
   localparam logic [2:0] STAT_ABSENT  = 3'd3;
   localparam logic [2:0] STAT_EMPTY   = 3'd4;
   localparam logic [2:0] STAT_FULL    = 3'd5;
   localparam logic [2:0] STAT_LOOKUP  = 3'd6;
   localparam logic [2:0] STAT_NONE    = 3'd7;

   typedef enum logic [1:0] {
      CMD_IDLE,
      CMD_INSERT,
      CMD_REMOVE,
      CMD_READ
   } cmd_kind_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  src;
      logic [15:0]  dst;
      logic [31:0]  family;
   } cmd_type;

   // Contents of one cell.
   typedef struct packed {
      logic        valid;
      logic [15:0] src;
      logic [15:0] dst;
      logic [31:0] family;
   } entry_type;

   // Summary of the chain for the sequencer.
   typedef struct packed {
      logic        hit;
      logic        full;
      logic [31:0] family;
   } chain_status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_PRIMARY,
      SEQ_MIRROR,
      SEQ_SRC_ONLY,
      SEQ_DST_ONLY
   } seq_state_type;

   // Bit i of the result is set when any bit at position i or below is set.
   function automatic logic [TableEntries-1:0] prefix_or(input logic [TableEntries-1:0] v);
      logic [TableEntries-1:0] r;
      r = v;
      for (int k = 1; k < TableEntries; k = k * 2) begin
         r = r | (r << k);
      end
      return r;
   endfunction

endpackage

### hw/rtl/port_pair_protocol_table_core.sv
// Top level of the port pair protocol table: command sequencer around the cell chain.
// Depends on ppt_pkg, ppt_chain and assert_macros.svh.
//
//   channel   direction  handshake            word
//   req_*     in         start high, busy low  op, ports, protocol, symmetrical
//   rsp_*     out        rsp_valid strobe      status, mirror status, three protocols
//
// The chain handles one key per cycle; a word is captured, then its keys go through the chain in turn.
// Rejected and bad words answer at capture with no chain work. Insert/remove touch the
// key, then the swapped pair if it applies. Lookup reads the exact key, and on a miss
// also reads the source-only and destination-only keys. busy drops as the result strobe rises.
// Reset empties the table. The receiver cannot stall results.
`include "assert_macros.svh"

module port_pair_protocol_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [31:0] req_protocol,
   input  logic        req_symmetrical,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_mirror_status,
   output logic [31:0] rsp_exact_protocol,
   output logic [31:0] rsp_src_match_protocol,
   output logic [31:0] rsp_dst_match_protocol
);

   ppt_pkg::seq_state_type    state_ff, state_in;
   logic [1:0]                op_ff, op_in;
   logic [15:0]               src_ff, src_in;
   logic [15:0]               dst_ff, dst_in;
   logic [31:0]               family_ff, family_in;
   logic                      mirror_ff, mirror_in;
   logic [2:0]                status_ff, status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [2:0]                rsp_status_ff, rsp_status_in;
   logic [2:0]                rsp_mirror_ff, rsp_mirror_in;
   logic [31:0]               rsp_exact_ff, rsp_exact_in;
   logic [31:0]               rsp_src_ff, rsp_src_in;
   logic [31:0]               rsp_dst_ff, rsp_dst_in;

   ppt_pkg::cmd_type          cmd;
   ppt_pkg::chain_status_type chain_stat;
   logic                      accept;
   logic [2:0]                update_status;

   assign accept = start && (state_ff == ppt_pkg::SEQ_IDLE);
   assign busy   = (state_ff != ppt_pkg::SEQ_IDLE);

   ppt_chain u_chain (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (chain_stat)
   );

   // Outcome of the insert or remove that the chain performs this cycle.
   always_comb begin
      if (op_ff == ppt_pkg::OP_INSERT) begin
         if (chain_stat.hit) begin
            update_status = ppt_pkg::STAT_UPDATED;
         end else if (chain_stat.full) begin
            update_status = ppt_pkg::STAT_FULL;
         end else begin
            update_status = ppt_pkg::STAT_NEW;
         end
      end else begin
         update_status = chain_stat.hit ? ppt_pkg::STAT_REMOVED : ppt_pkg::STAT_ABSENT;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      family_in     = family_ff;
      mirror_in     = mirror_ff;
      status_in     = status_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_mirror_in = rsp_mirror_ff;
      rsp_exact_in  = rsp_exact_ff;
      rsp_src_in    = rsp_src_ff;
      rsp_dst_in    = rsp_dst_ff;
      cmd.kind      = ppt_pkg::CMD_IDLE;
      cmd.src       = src_ff;
      cmd.dst       = dst_ff;
      cmd.family    = family_ff;

      case (state_ff)
         ppt_pkg::SEQ_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               src_in    = req_src_port;
               dst_in    = req_dst_port;
               family_in = req_protocol;
               mirror_in = req_symmetrical &&
                           ((req_src_port != req_dst_port) || (req_src_port == 16'd0));
               if (req_op == ppt_pkg::OP_BAD ||
                   (req_op == ppt_pkg::OP_INSERT && req_src_port == 16'd0 &&
                    req_dst_port == 16'd0)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = (req_op == ppt_pkg::OP_BAD) ? ppt_pkg::STAT_NONE
                                                              : ppt_pkg::STAT_EMPTY;
                  rsp_mirror_in = ppt_pkg::STAT_NONE;
                  rsp_exact_in  = '0;
                  rsp_src_in    = '0;
                  rsp_dst_in    = '0;
               end else begin
                  state_in = ppt_pkg::SEQ_PRIMARY;
               end
            end
         end
         ppt_pkg::SEQ_PRIMARY: begin
            if (op_ff == ppt_pkg::OP_LOOKUP) begin
               cmd.kind     = ppt_pkg::CMD_READ;
               rsp_exact_in = chain_stat.family;
               rsp_src_in   = '0;
               rsp_dst_in   = '0;
               if (chain_stat.hit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ppt_pkg::STAT_LOOKUP;
                  rsp_mirror_in = ppt_pkg::STAT_NONE;
                  state_in      = ppt_pkg::SEQ_IDLE;
               end else begin
                  state_in = ppt_pkg::SEQ_SRC_ONLY;
               end
            end else begin
               cmd.kind = (op_ff == ppt_pkg::OP_INSERT) ? ppt_pkg::CMD_INSERT
                                                        : ppt_pkg::CMD_REMOVE;
               status_in = update_status;
               if (mirror_ff) begin
                  state_in = ppt_pkg::SEQ_MIRROR;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = update_status;
                  rsp_mirror_in = ppt_pkg::STAT_NONE;
                  rsp_exact_in  = '0;
                  rsp_src_in    = '0;
                  rsp_dst_in    = '0;
                  state_in      = ppt_pkg::SEQ_IDLE;
               end
            end
         end
         ppt_pkg::SEQ_MIRROR: begin
            cmd.kind      = (op_ff == ppt_pkg::OP_INSERT) ? ppt_pkg::CMD_INSERT
                                                          : ppt_pkg::CMD_REMOVE;
            cmd.src       = dst_ff;
            cmd.dst       = src_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_mirror_in = update_status;
            rsp_exact_in  = '0;
            rsp_src_in    = '0;
            rsp_dst_in    = '0;
            state_in      = ppt_pkg::SEQ_IDLE;
         end
         ppt_pkg::SEQ_SRC_ONLY: begin
            cmd.kind   = ppt_pkg::CMD_READ;
            cmd.dst    = '0;
            rsp_src_in = chain_stat.family;
            state_in   = ppt_pkg::SEQ_DST_ONLY;
         end
         ppt_pkg::SEQ_DST_ONLY: begin
            cmd.kind      = ppt_pkg::CMD_READ;
            cmd.src       = '0;
            rsp_dst_in    = chain_stat.family;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ppt_pkg::STAT_LOOKUP;
            rsp_mirror_in = ppt_pkg::STAT_NONE;
            state_in      = ppt_pkg::SEQ_IDLE;
         end
         default: begin
            state_in = ppt_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppt_pkg::SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      family_ff     <= family_in;
      mirror_ff     <= mirror_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mirror_ff <= rsp_mirror_in;
      rsp_exact_ff  <= rsp_exact_in;
      rsp_src_ff    <= rsp_src_in;
      rsp_dst_ff    <= rsp_dst_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_mirror_status      = rsp_mirror_ff;
   assign rsp_exact_protocol     = rsp_exact_ff;
   assign rsp_src_match_protocol = rsp_src_ff;
   assign rsp_dst_match_protocol = rsp_dst_ff;

   // An accepted word either starts chain work or answers in the next cycle.
   `PPT_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid)
   // Lookups never report a swapped-pair operation.
   `PPT_ASSERT_NOW(a_lookup_no_mirror, clock, reset,
      rsp_valid && (rsp_status == ppt_pkg::STAT_LOOKUP), rsp_mirror_status == ppt_pkg::STAT_NONE)
   // Only lookups carry protocol codes.
   `PPT_ASSERT_NOW(a_codes_only_on_lookup, clock, reset,
      rsp_valid && (rsp_status != ppt_pkg::STAT_LOOKUP),
      (rsp_exact_protocol == 32'd0) && (rsp_src_match_protocol == 32'd0) &&
      (rsp_dst_match_protocol == 32'd0))

endmodule

### hw/rtl/ppt_cell.sv
// One cell of the port pair table chain: holds a single key and its family code.
// Depends on ppt_pkg.
module ppt_cell (
   input  logic                clock,
   input  logic                reset,
   input  ppt_pkg::cmd_type    cmd,
   input  logic                hit_any,
   input  logic                shift,
   input  logic                lower_valid,
   input  ppt_pkg::entry_type  upper,
   output ppt_pkg::entry_type  ent,
   output logic                hit
);

   logic        valid_ff, valid_in;
   logic [15:0] src_ff, src_in;
   logic [15:0] dst_ff, dst_in;
   logic [31:0] family_ff, family_in;

   assign ent.valid  = valid_ff;
   assign ent.src    = src_ff;
   assign ent.dst    = dst_ff;
   assign ent.family = family_ff;

   assign hit = valid_ff && (src_ff == cmd.src) && (dst_ff == cmd.dst);

   // Valid cells stay packed at the low end of the chain, so the first free
   // cell is the one whose lower neighbor is valid.
   always_comb begin
      valid_in  = valid_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      family_in = family_ff;
      case (cmd.kind)
         ppt_pkg::CMD_INSERT: begin
            if (hit_any) begin
               if (hit) begin
                  family_in = cmd.family;
               end
            end else if (!valid_ff && lower_valid) begin
               valid_in  = 1'b1;
               src_in    = cmd.src;
               dst_in    = cmd.dst;
               family_in = cmd.family;
            end
         end
         ppt_pkg::CMD_REMOVE: begin
            // Every cell from the removed one upward takes its upper neighbor.
            if (shift) begin
               valid_in  = upper.valid;
               src_in    = upper.src;
               dst_in    = upper.dst;
               family_in = upper.family;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      family_ff <= family_in;
   end

endmodule

### hw/rtl/ppt_chain.sv
// Row of port pair table cells with neighbor links, hit prefix and read-out.
// Depends on ppt_pkg and ppt_cell.
module ppt_chain (
   input  logic                      clock,
   input  logic                      reset,
   input  ppt_pkg::cmd_type          cmd,
   output ppt_pkg::chain_status_type stat
);

   ppt_pkg::entry_type                  ents [ppt_pkg::TableEntries];
   logic [ppt_pkg::TableEntries-1:0]    hits;
   logic [ppt_pkg::TableEntries-1:0]    shifts;
   logic                                hit_any;
   logic [31:0]                         read_family;

   assign hit_any = |hits;
   assign shifts  = ppt_pkg::prefix_or(hits);

   for (genvar i = 0; i < ppt_pkg::TableEntries; i++) begin : g_cell
      ppt_pkg::entry_type upper;
      logic               lower_valid;

      if (i == ppt_pkg::TableEntries - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = ents[i+1];
      end

      if (i == 0) begin : g_bottom
         assign lower_valid = 1'b1;
      end else begin : g_above
         assign lower_valid = ents[i-1].valid;
      end

      ppt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .hit_any     (hit_any),
         .shift       (shifts[i]),
         .lower_valid (lower_valid),
         .upper       (upper),
         .ent         (ents[i]),
         .hit         (hits[i])
      );
   end

   // Keys are unique, so at most one cell hits and an OR selects its code.
   always_comb begin
      read_family = '0;
      for (int i = 0; i < ppt_pkg::TableEntries; i++) begin
         read_family = read_family | (hits[i] ? ents[i].family : 32'd0);
      end
   end

   assign stat.hit    = hit_any;
   assign stat.full   = ents[ppt_pkg::TableEntries-1].valid;
   assign stat.family = read_family;

endmodule
